// ===== hdl/qufl_pkg.sv =====
// Shared types, widths and codes for the QUICK upwind face flux block.
`default_nettype none

package qufl_pkg;

    // Field widths of the stream words.
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned IN_DATA_W  = 6 * WORD_W;
    localparam int unsigned OUT_W      = 64;

    // Eight times the face value, in Q16.16 units, needs 36 signed bits.
    localparam int unsigned F8_W       = 36;
    localparam int unsigned MAG8_W     = F8_W - 1;
    localparam int unsigned F8_HI_W    = MAG8_W - WORD_W;

    // Area (64 bits) times speed (32 bits), then times |8f| (35 bits).
    localparam int unsigned AREA_W     = 2 * WORD_W;
    localparam int unsigned P1_W       = AREA_W + WORD_W;
    localparam int unsigned Q3_W       = P1_W + F8_HI_W;
    localparam int unsigned SA_W       = P1_W + 1;
    localparam int unsigned P2_W       = P1_W + MAG8_W + 1;

    // The full product has 67 fraction bits; the result keeps 32 of them.
    localparam int unsigned OUT_LSB    = 35;
    localparam int unsigned ROUND_BIT  = OUT_LSB - 1;

    typedef enum logic [1:0] {
        KIND_X    = 2'd0,
        KIND_Y    = 2'd1,
        KIND_Z    = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic {
        CFG_SPACING_X = 1'b0,
        CFG_SPACING_Y = 1'b1
    } cfg_index_t;

    // Operands of the curvature stencil.
    typedef struct packed {
        logic [WORD_W-1:0] velocity;
        logic              area_zero;
        logic [WORD_W-1:0] c_behind;
        logic [WORD_W-1:0] c_here;
        logic [WORD_W-1:0] c_ahead;
        logic [WORD_W-1:0] c_ahead2;
    } stencil_in_t;

    // Magnitude of eight times the face value and the sign of the flux.
    typedef struct packed {
        logic [MAG8_W-1:0] mag;
        logic              neg;
    } stencil_t;

endpackage

`default_nettype wire

// ===== hdl/qufl_stencil.sv =====
// Upwind or downwind QUICK stencil: eight times the face value, split into sign and magnitude.
`default_nettype none

module qufl_stencil (
    input  qufl_pkg::stencil_in_t stin,
    output qufl_pkg::stencil_t    stout
);
    import qufl_pkg::*;

    logic signed [F8_W-1:0] b_ext;
    logic signed [F8_W-1:0] h_ext;
    logic signed [F8_W-1:0] a_ext;
    logic signed [F8_W-1:0] a2_ext;
    logic signed [F8_W-1:0] f8_up;
    logic signed [F8_W-1:0] f8_dn;
    logic signed [F8_W-1:0] f8;
    logic                   upwind;

    assign b_ext  = F8_W'($signed(stin.c_behind));
    assign h_ext  = F8_W'($signed(stin.c_here));
    assign a_ext  = F8_W'($signed(stin.c_ahead));
    assign a2_ext = F8_W'($signed(stin.c_ahead2));

    // 4*(here + ahead) - (ahead - 2*here + behind) = 6*here + 3*ahead - behind.
    assign f8_up = (h_ext <<< 2) + (h_ext <<< 1) + (a_ext <<< 1) + a_ext - b_ext;
    // 4*(here + ahead) - (ahead2 - 2*ahead + here) = 3*here + 6*ahead - ahead2.
    assign f8_dn = (h_ext <<< 1) + h_ext + (a_ext <<< 2) + (a_ext <<< 1) - a2_ext;

    // The upwind cell sits behind only for a strictly positive mass flux.
    assign upwind = !stin.velocity[WORD_W-1] && (stin.velocity != '0) && !stin.area_zero;
    assign f8     = upwind ? f8_up : f8_dn;

    assign stout.mag = f8[F8_W-1] ? MAG8_W'(-f8) : MAG8_W'(f8);
    assign stout.neg = stin.velocity[WORD_W-1] != f8[F8_W-1];

endmodule

`default_nettype wire

// ===== hdl/quick_upwind_face_flux.sv =====
// Top level: pipelined QUICK upwind advective flux through one cell face.
`default_nettype none

// Channel   Direction  Payload (lowest bit first)
// s_axis    in         tdata: velocity, cell_height, c_behind, c_here, c_ahead, c_ahead2
//                      tuser: kind
// m_axis    out        tdata: face_flux; tuser: saturated
// cfg       in         cfg_index (0 spacing_x, 1 spacing_y), cfg_data
//
// The block takes one word per cycle unless a stalled output holds it back.
// Seven register stages hold the area product, the two halves of the mass flux
// product, the mass flux, the four partial products with |8f|, two partial sums,
// the full product with the rounding half added and the saturated result, which
// is the output register.
// Every stage has its own valid bit and loads whenever it is empty or the stage
// after it moves, so a stalled output only halts stages that are full and
// bubbles keep closing up behind it. Reset clears the valid bits and sets both
// spacings to 1.0; the configuration port is always ready.

module quick_upwind_face_flux (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // velocity, cell_height, c_behind, c_here, c_ahead, c_ahead2 (32 bits each)
    input  wire logic [qufl_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // kind
    input  wire logic [1:0]                     s_axis_tuser,

    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // face_flux
    output logic [qufl_pkg::OUT_W-1:0]          m_axis_tdata,
    // saturated
    output logic                                m_axis_tuser,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic                           cfg_index,
    input  wire logic [qufl_pkg::WORD_W-1:0]    cfg_data
);
    import qufl_pkg::*;

    localparam int unsigned NSTAGE = 7;

    // Configuration registers.
    logic [WORD_W-1:0] spacing_x_reg;
    logic [WORD_W-1:0] spacing_y_reg;

    // Pipeline control.
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] load;

    // Input word fields.
    kind_t             in_kind;
    logic [WORD_W-1:0] in_velocity;
    logic [WORD_W-1:0] in_height;

    // Stage 1: area, |velocity|, |8f| and sign.
    logic [WORD_W-1:0] op_a;
    logic [WORD_W-1:0] op_b;
    stencil_in_t       st_in;
    stencil_t          st_out;
    logic [AREA_W-1:0] area_next;
    logic [AREA_W-1:0] area_reg;
    logic [WORD_W-1:0] avel_next;
    logic [WORD_W-1:0] avel_reg;
    logic [MAG8_W-1:0] mag8_s1_reg;
    logic [NSTAGE-2:0] neg_reg;

    // Stage 2: two halves of area * |velocity|.
    logic [AREA_W-1:0] pa_lo_next;
    logic [AREA_W-1:0] pa_hi_next;
    logic [AREA_W-1:0] pa_lo_reg;
    logic [AREA_W-1:0] pa_hi_reg;
    logic [MAG8_W-1:0] mag8_s2_reg;

    // Stage 3: mass flux magnitude.
    logic [P1_W-1:0]   p1_next;
    logic [P1_W-1:0]   p1_reg;
    logic [MAG8_W-1:0] mag8_s3_reg;

    // Stage 4: partial products of mass flux and |8f|.
    logic [AREA_W-1:0] q0_next;
    logic [AREA_W-1:0] q1_next;
    logic [AREA_W-1:0] q2_next;
    logic [Q3_W-1:0]   q3_next;
    logic [AREA_W-1:0] q0_reg;
    logic [AREA_W-1:0] q1_reg;
    logic [AREA_W-1:0] q2_reg;
    logic [Q3_W-1:0]   q3_reg;

    // Stage 5: two partial sums.
    logic [SA_W-1:0]   sa_next;
    logic [P2_W-1:0]   sb_next;
    logic [SA_W-1:0]   sa_reg;
    logic [P2_W-1:0]   sb_reg;

    // Stage 6: full product with the rounding half added.
    logic [P2_W-1:0]   p2_next;
    logic [P2_W-1:0]   p2_reg;

    // Stage 7: output register.
    logic              over;
    logic [OUT_W-1:0]  mag;
    logic [OUT_W-1:0]  flux_next;
    logic              sat_next;
    logic [OUT_W-1:0]  flux_reg;
    logic              sat_reg;

    assign in_kind     = kind_t'(s_axis_tuser);
    assign in_velocity = s_axis_tdata[WORD_W-1:0];
    assign in_height   = s_axis_tdata[2*WORD_W-1:WORD_W];

    // ---------------------------------------------------------------
    // Configuration: taken in any cycle.
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_x_reg <= WORD_W'(65536);
            spacing_y_reg <= WORD_W'(65536);
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SPACING_X: spacing_x_reg <= cfg_data;
                CFG_SPACING_Y: spacing_y_reg <= cfg_data;
                default:       spacing_x_reg <= spacing_x_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its successor
    // loads; the last stage empties into the output handshake.
    // ---------------------------------------------------------------
    always_comb
    begin
        load[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_axis_tready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load[0])
        begin
            valid_next[0] = s_axis_tvalid;
        end
        for (int i = 1; i < NSTAGE; i++)
        begin
            if (load[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_axis_tready = load[0];
    assign m_axis_tvalid = valid_reg[NSTAGE-1];
    assign m_axis_tdata  = flux_reg;
    assign m_axis_tuser  = sat_reg;

    // ---------------------------------------------------------------
    // Stage 1. The area is the product of the two side lengths of the
    // face; an unused axis code forces it to zero. A product of two
    // unsigned values is zero exactly when one of them is, which lets
    // the stencil choose its cells in parallel with the multiplier.
    // ---------------------------------------------------------------
    always_comb
    begin
        case (in_kind)
            KIND_X:
            begin
                op_a = spacing_y_reg;
                op_b = in_height;
            end
            KIND_Y:
            begin
                op_a = spacing_x_reg;
                op_b = in_height;
            end
            KIND_Z:
            begin
                op_a = spacing_x_reg;
                op_b = spacing_y_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign area_next = AREA_W'(op_a) * AREA_W'(op_b);
    assign avel_next = in_velocity[WORD_W-1] ? (~in_velocity + WORD_W'(1)) : in_velocity;

    assign st_in.velocity  = in_velocity;
    assign st_in.area_zero = (op_a == '0) || (op_b == '0);
    assign st_in.c_behind  = s_axis_tdata[3*WORD_W-1:2*WORD_W];
    assign st_in.c_here    = s_axis_tdata[4*WORD_W-1:3*WORD_W];
    assign st_in.c_ahead   = s_axis_tdata[5*WORD_W-1:4*WORD_W];
    assign st_in.c_ahead2  = s_axis_tdata[6*WORD_W-1:5*WORD_W];

    qufl_stencil u_stencil (
        .stin  (st_in),
        .stout (st_out)
    );

    // ---------------------------------------------------------------
    // Stage 2: area times |velocity| as two 32 by 32 products.
    // ---------------------------------------------------------------
    assign pa_lo_next = AREA_W'(area_reg[WORD_W-1:0]) * AREA_W'(avel_reg);
    assign pa_hi_next = AREA_W'(area_reg[AREA_W-1:WORD_W]) * AREA_W'(avel_reg);

    // Stage 3: mass flux magnitude, 48 fraction bits.
    assign p1_next = P1_W'(pa_lo_reg) + {pa_hi_reg, {WORD_W{1'b0}}};

    // ---------------------------------------------------------------
    // Stage 4: mass flux times |8f|. The low 32 bits of |8f| meet each
    // 32 bit limb of the mass flux; its top three bits are shift-adds.
    // ---------------------------------------------------------------
    assign q0_next = AREA_W'(p1_reg[WORD_W-1:0]) * AREA_W'(mag8_s3_reg[WORD_W-1:0]);
    assign q1_next = AREA_W'(p1_reg[2*WORD_W-1:WORD_W]) * AREA_W'(mag8_s3_reg[WORD_W-1:0]);
    assign q2_next = AREA_W'(p1_reg[P1_W-1:2*WORD_W]) * AREA_W'(mag8_s3_reg[WORD_W-1:0]);

    always_comb
    begin
        q3_next = '0;
        for (int k = 0; k < int'(F8_HI_W); k++)
        begin
            if (mag8_s3_reg[WORD_W+k])
            begin
                q3_next = q3_next + (Q3_W'(p1_reg) << k);
            end
        end
    end

    // Stage 5: combine the partial products in two independent sums.
    assign sa_next = SA_W'(q0_reg) + {1'b0, q1_reg, {WORD_W{1'b0}}};
    assign sb_next = P2_W'({q2_reg, {2*WORD_W{1'b0}}}) + P2_W'({q3_reg, {WORD_W{1'b0}}});

    // Stage 6: full product with half an output step added, so the cut
    // below rounds halves away from zero.
    assign p2_next = sb_reg + P2_W'(sa_reg) + (P2_W'(1) << ROUND_BIT);

    // ---------------------------------------------------------------
    // Stage 7: take the Q32.32 magnitude, clip it and apply the sign.
    // A negative result may reach -2^63; a positive one stops at 2^63-1.
    // ---------------------------------------------------------------
    assign over = |p2_reg[P2_W-1:OUT_LSB+OUT_W];
    assign mag  = over ? {OUT_W{1'b1}} : p2_reg[OUT_LSB+OUT_W-1:OUT_LSB];

    always_comb
    begin
        sat_next = over;
        if (neg_reg[5])
        begin
            if (mag[OUT_W-1] && (mag[OUT_W-2:0] != '0))
            begin
                sat_next  = 1'b1;
                flux_next = {1'b1, {(OUT_W-1){1'b0}}};
            end
            else
            begin
                flux_next = ~mag + OUT_W'(1);
            end
        end
        else
        begin
            if (mag[OUT_W-1])
            begin
                sat_next  = 1'b1;
                flux_next = {1'b0, {(OUT_W-1){1'b1}}};
            end
            else
            begin
                flux_next = mag;
            end
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers; they need no reset.
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            area_reg    <= area_next;
            avel_reg    <= avel_next;
            mag8_s1_reg <= st_out.mag;
            neg_reg[0]  <= st_out.neg;
        end
        if (load[1])
        begin
            pa_lo_reg   <= pa_lo_next;
            pa_hi_reg   <= pa_hi_next;
            mag8_s2_reg <= mag8_s1_reg;
            neg_reg[1]  <= neg_reg[0];
        end
        if (load[2])
        begin
            p1_reg      <= p1_next;
            mag8_s3_reg <= mag8_s2_reg;
            neg_reg[2]  <= neg_reg[1];
        end
        if (load[3])
        begin
            q0_reg      <= q0_next;
            q1_reg      <= q1_next;
            q2_reg      <= q2_next;
            q3_reg      <= q3_next;
            neg_reg[3]  <= neg_reg[2];
        end
        if (load[4])
        begin
            sa_reg      <= sa_next;
            sb_reg      <= sb_next;
            neg_reg[4]  <= neg_reg[3];
        end
        if (load[5])
        begin
            p2_reg      <= p2_next;
            neg_reg[5]  <= neg_reg[4];
        end
        if (load[6])
        begin
            flux_reg    <= flux_next;
            sat_reg     <= sat_next;
        end
    end

endmodule

`default_nettype wire

// ===== verif/tb_quick_upwind_face_flux.sv =====
// Self-checking testbench for the QUICK upwind face flux block, with directed and random words.
module tb_quick_upwind_face_flux;
    import qufl_pkg::*;

    localparam int          HALF_PERIOD  = 6;
    localparam int          RESET_CYCLES = 11;
    localparam int          IDLE_LIMIT   = 1000;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          MAX_WAIT     = 5;
    localparam int          PHASE_FACES  = 256;
    localparam logic [31:0] ONE          = 32'h0001_0000;
    localparam logic [31:0] POS_MAX      = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAX      = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;

    typedef struct {
        kind_t       kind;
        logic [31:0] velocity;
        logic [31:0] cell_height;
        logic [31:0] c_behind;
        logic [31:0] c_here;
        logic [31:0] c_ahead;
        logic [31:0] c_ahead2;
    } face_t;

    typedef struct {
        logic [63:0] flux;
        logic        saturated;
    } flux_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata  = '0;
    logic [1:0]           s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_index     = 1'b0;
    logic [WORD_W-1:0]    cfg_data      = '0;

    // Our copy of the two spacing registers, updated when a write is taken.
    logic [31:0] spacing_x_now = ONE;
    logic [31:0] spacing_y_now = ONE;

    flux_t pending_flux[$];
    int    mismatches   = 0;
    int    idle_cycles  = 0;
    int    sink_wait    = 0;
    bit    source_gaps  = 1'b1;
    bit    sink_gaps    = 1'b1;

    quick_upwind_face_flux i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Flux through one face: area times velocity times the QUICK face value,
    // formed exactly and rounded once to Q32.32, halves away from zero.
    function automatic flux_t quick_flux(input face_t f);
        logic [63:0]  area;
        longint       vel;
        longint       cb;
        longint       ch;
        longint       ca;
        longint       ca2;
        longint       f8;
        logic [31:0]  speed;
        logic [35:0]  f8_mag;
        logic [159:0] prod;
        logic [63:0]  mag;
        logic         neg;
        flux_t        r;
        case (f.kind)
            KIND_X:  area = 64'(spacing_y_now) * 64'(f.cell_height);
            KIND_Y:  area = 64'(spacing_x_now) * 64'(f.cell_height);
            KIND_Z:  area = 64'(spacing_x_now) * 64'(spacing_y_now);
            default: area = '0;
        endcase
        vel = longint'($signed(f.velocity));
        cb  = longint'($signed(f.c_behind));
        ch  = longint'($signed(f.c_here));
        ca  = longint'($signed(f.c_ahead));
        ca2 = longint'($signed(f.c_ahead2));
        // Eight times the face value; the stencil leans upwind of the mass flux.
        if (vel > 0 && area != 0)
            f8 = 4 * (ch + ca) - (ca - 2 * ch + cb);
        else
            f8 = 4 * (ch + ca) - (ca2 - 2 * ca + ch);
        speed  = 32'(vel < 0 ? -vel : vel);
        f8_mag = 36'(f8 < 0 ? -f8 : f8);
        neg    = (vel < 0) != (f8 < 0);
        prod   = 160'(area) * 160'(speed) * 160'(f8_mag);
        prod   = prod + (160'd1 << ROUND_BIT);
        r.saturated = 1'b0;
        if (|prod[159:OUT_LSB + OUT_W])
        begin
            r.saturated = 1'b1;
            mag = '1;
        end
        else
        begin
            mag = prod[OUT_LSB +: OUT_W];
        end
        if (neg)
        begin
            if (mag > 64'h8000_0000_0000_0000)
            begin
                r.saturated = 1'b1;
                mag = 64'h8000_0000_0000_0000;
            end
            r.flux = 64'd0 - mag;
        end
        else
        begin
            if (mag > 64'h7FFF_FFFF_FFFF_FFFF)
            begin
                r.saturated = 1'b1;
                mag = 64'h7FFF_FFFF_FFFF_FFFF;
            end
            r.flux = mag;
        end
        return r;
    endfunction

    function automatic face_t make_face(input kind_t k, input logic [31:0] vel, hgt,
                                        input logic [31:0] cb, ch, ca, ca2);
        face_t f;
        f.kind        = k;
        f.velocity    = vel;
        f.cell_height = hgt;
        f.c_behind    = cb;
        f.c_here      = ch;
        f.c_ahead     = ca;
        f.c_ahead2    = ca2;
        return f;
    endfunction

    // Magnitudes spread over all bit lengths, with the extremes now and then.
    function automatic logic [31:0] random_magnitude();
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:
            begin
                case ($urandom_range(0, 4))
                    0:       return ALL_ONES;
                    1:       return POS_MAX;
                    2:       return NEG_MAX;
                    3:       return ONE;
                    default: return 32'd1;
                endcase
            end
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic [31:0] random_signed();
        logic [31:0] m;
        m = random_magnitude();
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    function automatic logic [31:0] random_spacing();
        logic [31:0] s;
        s = random_magnitude();
        return (s == 0) ? 32'd1 : s;
    endfunction

    function automatic face_t random_face();
        face_t       f;
        logic [31:0] base;
        f.kind        = ($urandom_range(0, 15) == 0) ? KIND_NONE
                                                     : kind_t'($urandom_range(0, 2));
        f.velocity    = random_signed();
        f.cell_height = random_spacing();
        if ($urandom_range(0, 1))
        begin
            f.c_behind = random_signed();
            f.c_here   = random_signed();
            f.c_ahead  = random_signed();
            f.c_ahead2 = random_signed();
        end
        else
        begin
            // A smooth field: four neighbors within half a unit of a shared base.
            base       = random_signed();
            f.c_behind = base + 32'($urandom_range(0, 65535)) - 32'd32768;
            f.c_here   = base + 32'($urandom_range(0, 65535)) - 32'd32768;
            f.c_ahead  = base + 32'($urandom_range(0, 65535)) - 32'd32768;
            f.c_ahead2 = base + 32'($urandom_range(0, 65535)) - 32'd32768;
        end
        return f;
    endfunction

    // Valid stays high after a word is taken, so back-to-back words need no
    // second assignment in the same step; a gap lowers it first.
    task automatic send_face(input face_t f);
        int gap;
        gap = source_gaps ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {f.c_ahead2, f.c_ahead, f.c_here, f.c_behind,
                          f.cell_height, f.velocity};
        s_axis_tuser  <= f.kind;
        do @(posedge clk); while (!s_axis_tready);
        pending_flux.push_back(quick_flux(f));
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (pending_flux.size() != 0) @(posedge clk);
    endtask

    // Both registers are written back to back, only once the pipeline is empty.
    task automatic set_spacings(input logic [31:0] sx, input logic [31:0] sy);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SPACING_X;
        cfg_data  <= sx;
        do @(posedge clk); while (!cfg_ready);
        spacing_x_now = sx;
        cfg_index <= CFG_SPACING_Y;
        cfg_data  <= sy;
        do @(posedge clk); while (!cfg_ready);
        spacing_y_now = sy;
        cfg_valid <= 1'b0;
    endtask

    // Every axis, both stencil directions, zero area and rounding of halves.
    task automatic test_stencils();
        send_face(make_face(KIND_X, ONE, ONE, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000));
        send_face(make_face(KIND_Y, -ONE, ONE, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000));
        send_face(make_face(KIND_Z, 32'd0, ONE, 32'h1_0000, 32'h5_0000, 32'h2_0000, 32'h9_0000));
        send_face(make_face(KIND_NONE, ONE, ONE, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000));
        send_face(make_face(KIND_X, ONE, 32'd0, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000));
        // The exact product lands on half an output step, once per sign.
        send_face(make_face(KIND_X, 32'd1, 32'd1, 32'h8000, 32'h8000, 32'h8000, 32'h8000));
        send_face(make_face(KIND_X, ALL_ONES, 32'd1, 32'h8000, 32'h8000, 32'h8000, 32'h8000));
        send_face(make_face(KIND_Z, 32'h2_8000, ONE, -32'h3_0000, -32'h1_4000, 32'h0_C000,
                            -32'h7_0000));
    endtask

    // Field extremes, including clipping in both directions.
    task automatic test_extremes();
        send_face(make_face(KIND_X, POS_MAX, ALL_ONES, POS_MAX, POS_MAX, POS_MAX, POS_MAX));
        send_face(make_face(KIND_Y, NEG_MAX, ALL_ONES, POS_MAX, POS_MAX, POS_MAX, POS_MAX));
        send_face(make_face(KIND_Z, NEG_MAX, ONE, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX));
        send_face(make_face(KIND_X, POS_MAX, 32'd1, NEG_MAX, POS_MAX, NEG_MAX, POS_MAX));
        send_face(make_face(KIND_Y, 32'd1, ALL_ONES, POS_MAX, NEG_MAX, POS_MAX, NEG_MAX));
        send_face(make_face(KIND_X, ALL_ONES, POS_MAX, 32'd0, 32'd0, 32'd0, 32'd0));
    endtask

    // Largest, smallest and zero spacings.
    task automatic test_spacing_edges();
        set_spacings(ALL_ONES, ALL_ONES);
        send_face(make_face(KIND_Z, POS_MAX, ONE, POS_MAX, POS_MAX, POS_MAX, POS_MAX));
        send_face(make_face(KIND_Z, 32'd1, ONE, 32'd3, 32'd1, 32'd4, 32'd1));
        set_spacings(32'd1, 32'd0);
        send_face(make_face(KIND_Z, ONE, ONE, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000));
        send_face(make_face(KIND_X, ONE, ONE, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000));
        send_face(make_face(KIND_Y, ONE, ALL_ONES, POS_MAX, 32'h2_0000, NEG_MAX, 32'h4_0000));
        set_spacings(32'd0, 32'd1);
        send_face(make_face(KIND_Y, ONE, ONE, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000));
    endtask

    // One phase of random faces under one pair of spacings. Gaps on either
    // side switch off for whole stretches, and the source holds off once
    // until the pipeline has drained.
    task automatic test_random(input logic [31:0] sx, input logic [31:0] sy, input int count);
        set_spacings(sx, sy);
        for (int n = 0; n < count; n++)
        begin
            if (n % 64 == 0)
            begin
                source_gaps = ($urandom_range(0, 3) != 0);
                sink_gaps   = ($urandom_range(0, 3) != 0);
            end
            if (n == count / 2)
                wait_for_results();
            send_face(random_face());
        end
        source_gaps = 1'b1;
        sink_gaps   = 1'b1;
    endtask

    // Result sink: a fresh random stall is drawn after every word.
    always @(posedge clk or negedge rst_n)
    begin
        int stall;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_wait     <= 0;
        end
        else if (m_axis_tready && m_axis_tvalid)
        begin
            stall = sink_gaps ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                sink_wait     <= stall - 1;
            end
        end
        else if (!m_axis_tready)
        begin
            if (sink_wait == 0)
                m_axis_tready <= 1'b1;
            else
                sink_wait <= sink_wait - 1;
        end
    end

    // Every result word is checked against the oldest prediction.
    always @(posedge clk)
    begin
        flux_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_flux.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got flux %h saturated %b",
                         $time, m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = pending_flux.pop_front();
                if (m_axis_tdata !== want.flux)
                begin
                    mismatches++;
                    $display("%0t: face_flux expected %h, got %h",
                             $time, want.flux, m_axis_tdata);
                end
                if (m_axis_tuser !== want.saturated)
                begin
                    mismatches++;
                    $display("%0t: saturated expected %b, got %b",
                             $time, want.saturated, m_axis_tuser);
                end
            end
        end
    end

    // Watchdog: too many cycles in a row without any word taken ends the run.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_stencils();
        test_extremes();
        test_spacing_edges();
        test_random(ONE, ONE, PHASE_FACES);
        test_random(ALL_ONES, ALL_ONES, PHASE_FACES);
        test_random(32'd1, 32'd1, PHASE_FACES);
        test_random(random_spacing(), random_spacing(), PHASE_FACES);
        test_random(ONE >> $urandom_range(0, 4), ONE << $urandom_range(0, 4), PHASE_FACES);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== quick_upwind_face_flux.f =====
hdl/qufl_pkg.sv
hdl/qufl_stencil.sv
hdl/quick_upwind_face_flux.sv
verif/tb_quick_upwind_face_flux.sv
